### rtl/core/lrs_pkg.sv
// ============================================================================
// lrs_pkg - shared types and constants for the line raster stepper
// Coordinate, delta and error types, the queued work item, and register codes.
// ============================================================================
package lrs_pkg;

    localparam int COORD_BITS  = 12;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int SCREEN_BITS = 11;
    localparam int CMP_BITS    = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_BITS = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] mag_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic        [SCREEN_BITS-1:0] screen_t;
    typedef logic        [CFG_INDEX_BITS-1:0] cfg_index_t;

    // register indexes of the config port
    localparam cfg_index_t REG_SCREEN_WIDTH  = CFG_INDEX_BITS'(0);
    localparam cfg_index_t REG_SCREEN_HEIGHT = CFG_INDEX_BITS'(1);

    localparam screen_t SCREEN_WIDTH_RESET  = SCREEN_BITS'(144);
    localparam screen_t SCREEN_HEIGHT_RESET = SCREEN_BITS'(196);

    // input action codes
    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_STEP  = 1'b1;

    // one classified beat, as handed from front to back
    typedef struct packed {
        logic   is_step;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        mag_t   delta_x;
        mag_t   delta_y;
        logic   dir_x_negative;
        logic   dir_y_negative;
        err_t   error_init;
    } lrs_item_t;

    typedef struct packed {
        logic      push;
        lrs_item_t item;
    } lrs_push_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } lrs_q_status_t;

endpackage

### rtl/core/lrs_front.sv
// ============================================================================
// lrs_front - input classification and line setup
// Decodes the action and, for a start beat, works out deltas, step
// directions and the initial error term before the beat is queued.
// ============================================================================
module lrs_front
    import lrs_pkg::*;
(
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      action,
    input  coord_t    start_x,
    input  coord_t    start_y,
    input  coord_t    end_x,
    input  coord_t    end_y,
    input  logic      q_full,
    output lrs_push_t push_o
);

    logic signed [COORD_BITS:0] diff_x;
    logic signed [COORD_BITS:0] diff_y;
    mag_t dx;
    mag_t dy;

    assign in_stall = q_full;

    always_comb
    begin
        diff_x = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
        diff_y = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
        dx = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
        dy = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);

        push_o.push                = in_valid && !q_full;
        push_o.item.is_step        = (action == ACTION_STEP);
        push_o.item.start_x        = start_x;
        push_o.item.start_y        = start_y;
        push_o.item.end_x          = end_x;
        push_o.item.end_y          = end_y;
        push_o.item.delta_x        = dx;
        push_o.item.delta_y        = dy;
        // negative unless start lies strictly below end
        push_o.item.dir_x_negative = diff_x[COORD_BITS] || (diff_x == '0);
        push_o.item.dir_y_negative = diff_y[COORD_BITS] || (diff_y == '0);
        // halve toward zero: shift the magnitude, then apply the sign
        if (dx > dy)
        begin
            push_o.item.error_init = $signed({2'b00, dx >> 1});
        end
        else
        begin
            push_o.item.error_init = -$signed({2'b00, dy >> 1});
        end
    end

endmodule

### rtl/core/lrs_queue.sv
// ============================================================================
// lrs_queue - short work queue between front and back
// Small register FIFO; full and empty come straight from the fill count.
// ============================================================================
module lrs_queue
    import lrs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  lrs_push_t     push_i,
    input  logic          pop,
    output lrs_item_t     head,
    output lrs_q_status_t status
);

    lrs_item_t entries [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head             = entries[rd_ptr_reg];

    always_comb
    begin
        do_push     = push_i.push && !status.full;
        do_pop      = pop && status.not_empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_i.item;
        end
    end

endmodule

### rtl/core/lrs_back.sv
// ============================================================================
// lrs_back - line state and pixel stepping
// Holds the active line, applies the two-test error update per step beat
// and registers one result per beat with clipping and endpoint flags.
// ============================================================================
module lrs_back
    import lrs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  lrs_item_t     head,
    input  lrs_q_status_t q_status,
    output logic          pop,
    input  screen_t       screen_width,
    input  screen_t       screen_height,
    output logic          out_valid,
    input  logic          out_stall,
    output coord_t        pixel_x,
    output coord_t        pixel_y,
    output logic          on_screen,
    output logic          final_pixel,
    output logic          produced
);

    // line state
    logic   active_reg, active_next;
    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    coord_t goal_x_reg, goal_x_next;
    coord_t goal_y_reg, goal_y_next;
    mag_t   dx_reg, dx_next;
    mag_t   dy_reg, dy_next;
    logic   dxn_reg, dxn_next;
    logic   dyn_reg, dyn_next;
    err_t   err_reg, err_next;

    // result register
    logic   out_valid_reg, out_valid_next;
    coord_t px_reg, px_next;
    coord_t py_reg, py_next;
    logic   on_reg, on_next;
    logic   fin_reg, fin_next;
    logic   prod_reg, prod_next;

    logic   advance;
    err_t   neg_dx;
    err_t   pos_dx;
    err_t   pos_dy;
    logic   take_x;
    logic   take_y;
    logic   hit_goal;
    logic   in_window;
    logic [CMP_BITS-1:0] x_u;
    logic [CMP_BITS-1:0] y_u;

    assign advance = q_status.not_empty && (!out_valid_reg || !out_stall);
    assign pop     = advance;

    always_comb
    begin
        active_next    = active_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dxn_next       = dxn_reg;
        dyn_next       = dyn_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && out_stall;
        px_next        = px_reg;
        py_next        = py_reg;
        on_next        = on_reg;
        fin_next       = fin_reg;
        prod_next      = prod_reg;

        neg_dx = -$signed({2'b00, dx_reg});
        pos_dx = $signed({2'b00, dx_reg});
        pos_dy = $signed({2'b00, dy_reg});
        take_x = (err_reg > neg_dx);
        take_y = (err_reg < pos_dy);

        if (!head.is_step)
        begin
            cur_x_next  = head.start_x;
            cur_y_next  = head.start_y;
            goal_x_next = head.end_x;
            goal_y_next = head.end_y;
            dx_next     = head.delta_x;
            dy_next     = head.delta_y;
            dxn_next    = head.dir_x_negative;
            dyn_next    = head.dir_y_negative;
            err_next    = head.error_init;
        end
        else if (active_reg)
        begin
            err_next = err_reg - (take_x ? pos_dy : ERR_BITS'(0))
                               + (take_y ? pos_dx : ERR_BITS'(0));
            if (take_x)
            begin
                cur_x_next = dxn_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
            end
            if (take_y)
            begin
                cur_y_next = dyn_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1);
            end
        end

        // flags on the pixel about to be emitted
        x_u       = CMP_BITS'($unsigned(cur_x_next));
        y_u       = CMP_BITS'($unsigned(cur_y_next));
        hit_goal  = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
        in_window = !cur_x_next[COORD_BITS-1] && (x_u < CMP_BITS'(screen_width))
                 && !cur_y_next[COORD_BITS-1] && (y_u < CMP_BITS'(screen_height));

        if (advance)
        begin
            out_valid_next = 1'b1;
            if (head.is_step && !active_reg)
            begin
                px_next   = '0;
                py_next   = '0;
                on_next   = 1'b0;
                fin_next  = 1'b0;
                prod_next = 1'b0;
            end
            else
            begin
                px_next     = cur_x_next;
                py_next     = cur_y_next;
                on_next     = in_window;
                fin_next    = hit_goal;
                prod_next   = 1'b1;
                active_next = !hit_goal;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dxn_reg       <= 1'b0;
            dyn_reg       <= 1'b0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                active_reg <= active_next;
                cur_x_reg  <= cur_x_next;
                cur_y_reg  <= cur_y_next;
                goal_x_reg <= goal_x_next;
                goal_y_reg <= goal_y_next;
                dx_reg     <= dx_next;
                dy_reg     <= dy_next;
                dxn_reg    <= dxn_next;
                dyn_reg    <= dyn_next;
                err_reg    <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        on_reg   <= on_next;
        fin_reg  <= fin_next;
        prod_reg <= prod_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign on_screen   = on_reg;
    assign final_pixel = fin_reg;
    assign produced    = prod_reg;

endmodule

### rtl/core/line_raster_stepper_top.sv
// ============================================================================
// line_raster_stepper_top - Bresenham line stepper with screen clipping
// Path: an input beat is queued, then registered as a result beat by the back.
// Throughput: one beat per unstalled cycle, set by the error update loop.
// Reset: async active low; no line active, screen 144 x 196, queue empty.
// Config writes are taken every cycle (cfg_ready is always high).
// ============================================================================
//
// Structure:
//   lrs_front  - decodes action, computes |delta|, directions, initial error
//   lrs_queue  - two-entry FIFO; in_stall rises only when it fills, which
//                happens only while the result side holds stall
//   lrs_back   - owns the line state; pops one beat per cycle whenever the
//                result register is empty or being drained
//
// The screen size registers live here and feed the clip compare in the back.
// A write to an index outside the register list is accepted and dropped.
module line_raster_stepper_top
    import lrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  coord_t     start_x,
    input  coord_t     start_y,
    input  coord_t     end_x,
    input  coord_t     end_y,

    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output coord_t     pixel_x,
    output coord_t     pixel_y,
    output logic       on_screen,
    output logic       final_pixel,
    output logic       produced,

    // config write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  screen_t    cfg_data
);

    screen_t       width_reg, width_next;
    screen_t       height_reg, height_next;
    lrs_push_t     push;
    lrs_item_t     head;
    lrs_q_status_t q_status;
    logic          pop;

    assign cfg_ready = 1'b1;

    // register file decode
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_next  = cfg_data;
                REG_SCREEN_HEIGHT: height_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    lrs_front u_front
    (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .q_full   (q_status.full),
        .push_o   (push)
    );

    lrs_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_i (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    lrs_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .on_screen     (on_screen),
        .final_pixel   (final_pixel),
        .produced      (produced)
    );

endmodule

### dv/tb_line_raster_stepper_top.sv
// ============================================================================
// tb_line_raster_stepper_top - self-checking bench for the line raster stepper
// Drives start and step beats through the input channel, predicts each pixel
// with a behavioral Bresenham stepper, and compares every result beat in order.
// Covers directed corner lines, then random lines under four idle/stall mixes.
// ============================================================================
module tb_line_raster_stepper_top;
    import lrs_pkg::*;

    // indexes past the end of the register list; writes there must be dropped
    localparam cfg_index_t REG_UNUSED_A = cfg_index_t'(2);
    localparam cfg_index_t REG_UNUSED_B = cfg_index_t'(3);

    localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
    localparam int BEATS_PER_PHASE = 150;

    // one result beat as seen on the output ports
    typedef struct {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   on_screen;
        logic   final_pixel;
        logic   produced;
    } pixel_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: behavioral line stepper plus the queue of expected pixels.
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        screen_t     screen_w;
        screen_t     screen_h;
        coord_t      pos_x;
        coord_t      pos_y;
        coord_t      goal_x;
        coord_t      goal_y;
        mag_t        span_x;
        mag_t        span_y;
        logic        neg_x;
        logic        neg_y;
        err_t        err_acc;
        logic        drawing;
        pixel_beat_t expected_pixels[$];
        int          errors;

        function new();
            screen_w = SCREEN_WIDTH_RESET;
            screen_h = SCREEN_HEIGHT_RESET;
            pos_x = '0;
            pos_y = '0;
            goal_x = '0;
            goal_y = '0;
            span_x = '0;
            span_y = '0;
            neg_x = 1'b0;
            neg_y = 1'b0;
            err_acc = '0;
            drawing = 1'b0;
            errors = 0;
        endfunction

        function void set_screen(cfg_index_t idx, screen_t data);
            if (idx == REG_SCREEN_WIDTH)
                screen_w = data;
            else if (idx == REG_SCREEN_HEIGHT)
                screen_h = data;
        endfunction

        function pixel_beat_t current_pixel();
            pixel_beat_t b;
            int x;
            int y;
            x = pos_x;
            y = pos_y;
            b.pixel_x = pos_x;
            b.pixel_y = pos_y;
            b.on_screen = (x >= 0) && (x < int'(screen_w)) &&
                          (y >= 0) && (y < int'(screen_h));
            b.final_pixel = (pos_x == goal_x) && (pos_y == goal_y);
            b.produced = 1'b1;
            if (b.final_pixel)
                drawing = 1'b0;
            return b;
        endfunction

        // advance the line state for one accepted input beat
        function pixel_beat_t predict_pixel(logic act, coord_t sx, coord_t sy,
                                            coord_t ex, coord_t ey);
            pixel_beat_t b;
            int ax;
            int ay;
            int bx;
            int by;
            int dx;
            int dy;
            int prev_err;
            int e;
            int x;
            int y;
            if (act == ACTION_START) begin
                ax = sx;
                ay = sy;
                bx = ex;
                by = ey;
                dx = (bx > ax) ? bx - ax : ax - bx;
                dy = (by > ay) ? by - ay : ay - by;
                span_x = mag_t'(dx);
                span_y = mag_t'(dy);
                neg_x = !(ax < bx);
                neg_y = !(ay < by);
                // truncating divide, matches toward-zero halving of a negative
                err_acc = err_t'(((dx > dy) ? dx : -dy) / 2);
                pos_x = sx;
                pos_y = sy;
                goal_x = ex;
                goal_y = ey;
                drawing = 1'b1;
                return current_pixel();
            end
            if (!drawing) begin
                b.pixel_x = '0;
                b.pixel_y = '0;
                b.on_screen = 1'b0;
                b.final_pixel = 1'b0;
                b.produced = 1'b0;
                return b;
            end
            dx = int'(span_x);
            dy = int'(span_y);
            prev_err = err_acc;
            e = prev_err;
            x = pos_x;
            y = pos_y;
            // both tests look at the error from before this step
            if (prev_err > -dx) begin
                e -= dy;
                x += neg_x ? -1 : 1;
            end
            if (prev_err < dy) begin
                e += dx;
                y += neg_y ? -1 : 1;
            end
            err_acc = err_t'(e);
            pos_x = coord_t'(x);
            pos_y = coord_t'(y);
            return current_pixel();
        endfunction

        function void note_beat(logic act, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            expected_pixels.push_back(predict_pixel(act, sx, sy, ex, ey));
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_beat(pixel_beat_t got);
            pixel_beat_t exp_b;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual x=%0d y=%0d",
                         $time, got.pixel_x, got.pixel_y);
                return;
            end
            exp_b = expected_pixels.pop_front();
            compare_field("pixel_x", exp_b.pixel_x, got.pixel_x);
            compare_field("pixel_y", exp_b.pixel_y, got.pixel_y);
            compare_field("on_screen", exp_b.on_screen, got.on_screen);
            compare_field("final_pixel", exp_b.final_pixel, got.final_pixel);
            compare_field("produced", exp_b.produced, got.produced);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT hookup. All inputs start at known values.
    // ------------------------------------------------------------------------
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       action = ACTION_START;
    coord_t     start_x = '0;
    coord_t     start_y = '0;
    coord_t     end_x = '0;
    coord_t     end_y = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    coord_t     pixel_x;
    coord_t     pixel_y;
    logic       on_screen;
    logic       final_pixel;
    logic       produced;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = REG_SCREEN_WIDTH;
    screen_t    cfg_data = '0;

    pixel_scoreboard sb = new();

    // percent chance per cycle that the sender idles / the receiver stalls
    int idle_pct = 0;
    int stall_pct = 0;
    int beats_sent = 0;
    // screen size currently programmed, used to aim random lines in and around it
    int win_w = SCREEN_WIDTH_RESET;
    int win_h = SCREEN_HEIGHT_RESET;

    always #4 clk = ~clk;

    line_raster_stepper_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .on_screen   (on_screen),
        .final_pixel (final_pixel),
        .produced    (produced),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: values read right after the edge are the ones the DUT
    // presented at that edge, so a beat is taken when valid && !stall there.
    // Stall is redrawn every cycle, one nonblocking write per edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_beat_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.pixel_x = pixel_x;
            got.pixel_y = pixel_y;
            got.on_screen = on_screen;
            got.final_pixel = final_pixel;
            got.produced = produced;
            sb.check_beat(got);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic coord_t rand_coord();
        return coord_t'($urandom_range(4095));
    endfunction

    function automatic int clamp_coord(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Present one beat and hold it until taken. Valid stays high into the next
    // beat unless an idle gap is drawn, so it is never dropped and re-raised
    // within one time step.
    task automatic send_beat(logic act, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_beat(act, sx, sy, ex, ey);
        beats_sent++;
    endtask

    task automatic start_line(int ax, int ay, int bx, int by);
        send_beat(ACTION_START, coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by));
    endtask

    // endpoint fields are don't-care on a step; randomize them anyway
    task automatic send_step();
        send_beat(ACTION_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic write_reg(cfg_index_t idx, screen_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_screen(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait out every expected pixel, then the pipe plus margin
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed lines: a start in or around the screen followed by
    // its full run of steps (sometimes a couple of extra dead steps, sometimes
    // cut short by the next start). The rest is full-range lines that get
    // interrupted, and loose random beats.
    task automatic random_line();
        int pick;
        int ax;
        int ay;
        int bx;
        int by;
        int len;
        int n;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_beat(($urandom_range(1) == 0) ? ACTION_START : ACTION_STEP,
                      rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
        else if (pick < 18) begin
            send_beat(ACTION_START, rand_coord(), rand_coord(), rand_coord(), rand_coord());
            n = $urandom_range(40);
            repeat (n) send_step();
        end
        else begin
            ax = clamp_coord(int'($urandom_range(win_w + 16)) - 8);
            ay = clamp_coord(int'($urandom_range(win_h + 16)) - 8);
            bx = clamp_coord(ax + int'($urandom_range(48)) - 24);
            by = clamp_coord(ay + int'($urandom_range(48)) - 24);
            start_line(ax, ay, bx, by);
            len = abs_int(bx - ax);
            if (abs_int(by - ay) > len)
                len = abs_int(by - ay);
            if ($urandom_range(99) < 75)
                n = len + int'($urandom_range(2));
            else
                n = $urandom_range(len);
            repeat (n) send_step();
        end
    endtask

    // One traffic phase: reprogram the screen while idle (plus a write to an
    // unused index), then random lines under the given idle/stall mix.
    task automatic run_phase(int idle, int stall, screen_t w, screen_t h, cfg_index_t junk);
        int target;
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(junk, screen_t'($urandom));
        win_w = w;
        win_h = h;
        idle_pct = idle;
        stall_pct = stall;
        target = beats_sent + BEATS_PER_PHASE;
        while (beats_sent < target)
            random_line();
        in_valid <= 1'b0;
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at reset screen size (144 x 196), no idling.
        send_step();                              // step before any line: nothing produced
        start_line(5, 5, 5, 5);                   // endpoints equal: first pixel is final
        send_step();                              // line already closed
        start_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_step();
        send_step();
        start_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);  // restart mid-line
        send_step();
        start_line(0, 0, 3, 0);                   // flat line run to its end
        repeat (3) send_step();
        send_step();                              // past the end: nothing produced
        start_line(143, 195, 144, 196);           // last on-screen pixel, then off
        send_step();
        send_step();
        start_line(0, 0, -1, -3);                 // steep, both directions negative
        repeat (3) send_step();
        start_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_step();
        in_valid <= 1'b0;
        drain();

        // Random phases; screen size swept through its extremes.
        run_phase(0, 0, screen_t'(1), screen_t'(1), REG_UNUSED_A);
        run_phase(74, 0, screen_t'(2047), screen_t'(2047), REG_UNUSED_B);
        run_phase(0, 74, screen_t'($urandom_range(2047, 1)), screen_t'($urandom_range(64, 1)),
                  REG_UNUSED_A);
        run_phase(36, 36, SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET, REG_UNUSED_B);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
